/* rtl/wbps_pkg.sv */
// Shared constants, types and a length helper for the wildcard byte pattern search block.
package wbps_pkg;

   localparam int PatternMax = 16;
   localparam int WinIdxW    = $clog2(PatternMax);
   localparam int LenW       = 5;
   localparam int OffsetW    = 32;
   localparam int MaskW      = 16;
   localparam int WordW      = 64;
   localparam int CsrIdxW    = 2;

   typedef logic [7:0] byte_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_WILDCARD_MASK  = 2'd2,
      CSR_PATTERN_LENGTH = 2'd3
   } csr_index_type;

   // A length of zero acts as one, anything above the window depth acts as the depth.
   function automatic logic [LenW-1:0] clamp_length(input logic [LenW-1:0] raw);
      logic [LenW-1:0] len;
      len = raw;
      if (raw == '0) begin
         len = LenW'(1);
      end else if (raw > LenW'(PatternMax)) begin
         len = LenW'(PatternMax);
      end
      return len;
   endfunction

endpackage

/* rtl/wildcard_byte_pattern_search_top.sv */
// Top level of the wildcard byte pattern search: byte window, masked compare and result register.
//
//   Channel   Direction  Handshake           Payload
//   req       in         req_valid/req_stall req_data_byte, req_end_of_image
//   rsp       out        rsp_valid/rsp_stall rsp_found, rsp_match_offset
//   csr       in         csr_write_enable    csr_index, csr_write_data
//
// An item is captured in an input register; once the result register is free, the window shift,
// the sixteen masked byte compares and the offset subtraction are done in one pass and the
// result, if the item causes one, is written to the result register. One item is taken in
// every cycle while the result side does not stall; a result passes through the input register
// and then the result register on its way to the outputs.
// Reset clears the byte count, the match flag and the valid flags, and loads the pattern
// registers with zeros and the pattern length with one. The window needs no reset, since
// a compare only reads bytes of the current image.
// A stalled result holds the result register, which in turn holds the input register, so a
// stall on the result side reaches req_stall in the same cycle only while both are full.
module wildcard_byte_pattern_search_top
   import wbps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_image,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [OffsetW-1:0]  rsp_match_offset,
   input  logic                csr_write_enable,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [WordW-1:0]    csr_write_data
);

   // Configuration registers.
   logic [WordW-1:0]   pattern_low_ff,    pattern_low_in;
   logic [WordW-1:0]   pattern_high_ff,   pattern_high_in;
   logic [MaskW-1:0]   wildcard_mask_ff,  wildcard_mask_in;
   logic [LenW-1:0]    pattern_length_ff, pattern_length_in;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   byte_type           in_data_ff,  in_data_in;
   logic               in_last_ff,  in_last_in;

   // Scan state. The window is never cleared: a compare only looks at positions that
   // were filled within the current image, because it waits until enough bytes are seen.
   byte_type           window_ff [PatternMax];
   byte_type           window_in [PatternMax];
   logic [OffsetW-1:0] bytes_seen_ff, bytes_seen_in;
   logic               match_done_ff, match_done_in;

   // Result register.
   logic               rsp_valid_ff,  rsp_valid_in;
   logic               rsp_found_ff,  rsp_found_in;
   logic [OffsetW-1:0] rsp_offset_ff, rsp_offset_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  fire;
   logic [LenW-1:0]       active_len;
   logic [WinIdxW-1:0]    len_minus_one;
   logic [OffsetW-1:0]    seen_next;
   logic [2*WordW-1:0]    pattern_flat;
   logic                  all_match;
   logic                  hit;

   assign req_accept = req_valid && !req_stall;
   // The result register can take a new result when it is empty or being drained.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

   // Configuration writes.
   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      wildcard_mask_in  = wildcard_mask_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_in    = csr_write_data;
            CSR_PATTERN_HIGH:   pattern_high_in   = csr_write_data;
            CSR_WILDCARD_MASK:  wildcard_mask_in  = csr_write_data[MaskW-1:0];
            CSR_PATTERN_LENGTH: pattern_length_in = csr_write_data[LenW-1:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_last_in  = in_last_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data_byte;
         in_last_in  = req_end_of_image;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Window after this byte is shifted in: the newest byte sits at index zero.
   always_comb begin
      window_in[0] = in_data_ff;
      for (int j = 1; j < PatternMax; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   assign active_len    = clamp_length(pattern_length_ff);
   assign len_minus_one = WinIdxW'(active_len - LenW'(1));
   assign seen_next     = (bytes_seen_ff == '1) ? bytes_seen_ff : bytes_seen_ff + OffsetW'(1);
   assign pattern_flat  = {pattern_high_ff, pattern_low_ff};

   // Pattern byte k lines up with the window entry that is len-1-k bytes old.
   always_comb begin
      logic [WinIdxW-1:0] idx;
      all_match = 1'b1;
      for (int k = 0; k < PatternMax; k++) begin
         idx = len_minus_one - WinIdxW'(k);
         if ((LenW'(k) < active_len) && !wildcard_mask_ff[k]) begin
            if (window_in[idx] != pattern_flat[8*k +: 8]) begin
               all_match = 1'b0;
            end
         end
      end
   end

   assign hit = (seen_next >= OffsetW'(active_len)) && all_match;

   // Scan state and result register.
   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      match_done_in = match_done_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (fire) begin
         if (!match_done_ff) begin
            bytes_seen_in = seen_next;
            if (hit) begin
               match_done_in = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_offset_in = seen_next - OffsetW'(active_len);
            end else if (in_last_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_offset_in = '0;
            end
         end
         // The end-of-image byte always starts a fresh scan.
         if (in_last_ff) begin
            bytes_seen_in = '0;
            match_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= LenW'(1);
         in_valid_ff       <= 1'b0;
         bytes_seen_ff     <= '0;
         match_done_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         wildcard_mask_ff  <= wildcard_mask_in;
         pattern_length_ff <= pattern_length_in;
         in_valid_ff       <= in_valid_in;
         bytes_seen_ff     <= bytes_seen_in;
         match_done_ff     <= match_done_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_data_ff    <= in_data_in;
      in_last_ff    <= in_last_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
      if (fire && !match_done_ff) begin
         for (int j = 0; j < PatternMax; j++) begin
            window_ff[j] <= window_in[j];
         end
      end
   end

endmodule

/* tb/wildcard_byte_pattern_search_top_tb.sv */
// Self-checking testbench for the wildcard byte pattern search block.
module wildcard_byte_pattern_search_top_tb
   import wbps_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // The run is cut off here even if the block stops answering altogether.
   localparam int CycleLimit       = 400000;
   localparam int MaxReported      = 10;
   // Long enough for the block's small pipeline to fill and back up to the input.
   localparam int HoldOffCycles    = 250;
   localparam int RandomItemTarget = 960;
   // The last items of the random part run with no idling on either side.
   localparam int QuietTail        = 150;
   // Margin for the pipeline to empty after the last expected result, used whenever the block is settled.
   localparam int DrainCycles      = 4;

   typedef struct packed {
      logic               found;
      logic [OffsetW-1:0] offset;
   } scan_result_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   byte_type            req_data_byte    = '0;
   logic                req_end_of_image = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic                rsp_found;
   logic [OffsetW-1:0]  rsp_match_offset;
   logic                csr_write_enable = 1'b0;
   csr_index_type       csr_index        = CSR_PATTERN_LOW;
   logic [WordW-1:0]    csr_write_data   = '0;

   // Our own copy of the scanner: pattern registers plus the per-image scan state.
   logic [WordW-1:0]    pat_low    = '0;
   logic [WordW-1:0]    pat_high   = '0;
   logic [MaskW-1:0]    wild_bits  = '0;
   logic [LenW-1:0]     len_reg    = LenW'(1);
   byte_type            win [PatternMax];
   logic [OffsetW-1:0]  bytes_in_image;
   bit                  match_reported;

   scan_result_type     expected_results[$];
   int                  mismatch_count = 0;
   int                  live_bytes     = 0;
   int                  cycle_count    = 0;
   bit                  sender_gaps    = 1'b1;
   bit                  receiver_gaps  = 1'b1;
   bit                  hold_off_req   = 1'b0;

   wildcard_byte_pattern_search_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_image (req_end_of_image),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A length of zero behaves as one; anything past the window depth behaves as the depth.
   function automatic int effective_length(input logic [LenW-1:0] raw);
      if (raw == '0) begin
         return 1;
      end
      if (raw > PatternMax) begin
         return PatternMax;
      end
      return int'(raw);
   endfunction

   function automatic void clear_scan_state();
      win            = '{default: '0};
      bytes_in_image = '0;
      match_reported = 1'b0;
   endfunction

   // Advances the scan state by one byte. Returns 1 when the byte produces a result.
   function automatic bit predict_scan(input byte_type data, input logic eoi,
                                       output scan_result_type res);
      int                 n;
      bit                 hit;
      bit                 emitted;
      logic [2*WordW-1:0] pat;
      res     = '0;
      emitted = 1'b0;
      if (!match_reported) begin
         n = effective_length(len_reg);
         for (int i = PatternMax - 1; i > 0; i--) begin
            win[i] = win[i-1];
         end
         win[0] = data;
         if (bytes_in_image != '1) begin
            bytes_in_image++;
         end
         // Pattern byte 0 lines up with the oldest of the newest n bytes.
         pat = {pat_high, pat_low};
         hit = (bytes_in_image >= n);
         for (int k = 0; k < n; k++) begin
            if (!wild_bits[k] && win[n-1-k] != pat[8*k +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            res.found      = 1'b1;
            res.offset     = bytes_in_image - OffsetW'(n);
            match_reported = 1'b1;
            emitted        = 1'b1;
         end else if (eoi) begin
            emitted = 1'b1;
         end
      end
      if (eoi) begin
         clear_scan_state();
      end
      return emitted;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MaxReported) begin
         $display("[%0t] MISMATCH: %s", $realtime, what);
      end
   endtask

   // Offers one item, holds it steady through any stall, and predicts its result once taken.
   // A random gap may be inserted in front of the item while sender gaps are enabled.
   task automatic send_byte(input byte_type data, input logic eoi);
      scan_result_type res;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_end_of_image <= eoi;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      live_bytes++;
      if (predict_scan(data, eoi, res)) begin
         expected_results.insert(expected_results.size(), res);
      end
   endtask

   // Waits until every predicted result has come out, then lets the pipeline empty.
   // An item that produces no result may still be in flight, hence the extra cycles.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [WordW-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      case (idx)
         CSR_PATTERN_LOW:    pat_low   = value;
         CSR_PATTERN_HIGH:   pat_high  = value;
         CSR_WILDCARD_MASK:  wild_bits = value[MaskW-1:0];
         CSR_PATTERN_LENGTH: len_reg   = value[LenW-1:0];
         default: ;
      endcase
   endtask

   // Loads all four registers while the block is idle. The bits above the mask and the
   // length fields carry random junk, which the block has to ignore.
   task automatic load_pattern(input logic [WordW-1:0] low, input logic [WordW-1:0] high,
                               input logic [MaskW-1:0] mask, input logic [LenW-1:0] raw_len);
      logic [WordW-1:0] junk;
      junk = {$urandom(), $urandom()};
      settle_block();
      write_reg(CSR_PATTERN_LOW, low);
      write_reg(CSR_PATTERN_HIGH, high);
      write_reg(CSR_WILDCARD_MASK, {junk[WordW-1:MaskW], mask});
      write_reg(CSR_PATTERN_LENGTH, {junk[WordW-1:LenW], raw_len});
      csr_write_enable <= 1'b0;
   endtask

   // With the reset settings the pattern is the single byte zero, with no wildcard.
   task automatic test_reset_defaults();
      send_byte(8'hFF, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   // Length zero acts as one, lengths above sixteen act as sixteen. Also covers bytes
   // after a match, which are ignored, and an image shorter than the pattern.
   task automatic test_length_clamping();
      load_pattern(64'h0000_0000_0000_00FF, 64'h0, 16'h0000, 5'd0);
      send_byte(8'h12, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      load_pattern('1, '1, 16'hFFFF, 5'd31);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   // Pattern A5, any byte, 5A: a one-byte image cannot match, and the second image
   // matches exactly on its final byte.
   task automatic test_final_byte_match();
      load_pattern(64'hFFFF_FFFF_FF5A_C3A5, '1, 16'h0002, 5'd3);
      send_byte(8'hA5, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h77, 1'b0);
      send_byte(8'h5A, 1'b1);
   endtask

   // A new pattern loaded halfway through an image applies from the next byte on,
   // while the window and the byte count carry over.
   task automatic test_config_mid_image();
      load_pattern(64'h0000_0000_0000_2211, 64'h0, 16'h0000, 5'd2);
      send_byte(8'h11, 1'b0);
      load_pattern(64'h0000_0000_0000_0033, 64'h0, 16'h0000, 5'd1);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b1);
   endtask

   // The receiver holds off for a long stretch while one-byte images, each of which
   // matches, keep coming, so the block fills and has to stall its input.
   task automatic test_receiver_hold_off();
      load_pattern({$urandom(), $urandom()}, {$urandom(), $urandom()}, 16'h0001, 5'd1);
      sender_gaps  = 1'b0;
      hold_off_req = 1'b1;
      repeat (48) begin
         send_byte(byte_type'($urandom()), 1'b1);
      end
      settle_block();
      sender_gaps = 1'b1;
   endtask

   // Phases of random settings, each followed by a few images. Most images embed the
   // pattern (random bytes under the wildcards) between random filler; some carry a
   // corrupted or cut-short copy and some are pure noise.
   task automatic test_random_images();
      byte_type           img[$];
      logic [2*WordW-1:0] pat;
      logic [MaskW-1:0]   mask;
      logic [LenW-1:0]    raw_len;
      int                 n;
      int                 kind;
      int                 at;
      int                 start_count;
      bit                 quiet;
      start_count = live_bytes;
      while (live_bytes - start_count < RandomItemTarget) begin
         quiet         = (live_bytes - start_count > RandomItemTarget - QuietTail);
         sender_gaps   = !quiet && $urandom_range(0, 2) != 0;
         receiver_gaps = !quiet && $urandom_range(0, 2) != 0;
         case ($urandom_range(0, 5))
            0:       pat = '0;
            1:       pat = '1;
            default: pat = {$urandom(), $urandom(), $urandom(), $urandom()};
         endcase
         case ($urandom_range(0, 5))
            0:       mask = '0;
            1:       mask = '1;
            2:       mask = MaskW'($urandom());
            default: mask = MaskW'($urandom() & $urandom() & $urandom());
         endcase
         case ($urandom_range(0, 7))
            0:       raw_len = '0;
            1:       raw_len = LenW'(PatternMax);
            2:       raw_len = LenW'($urandom_range(PatternMax + 1, 31));
            3:       raw_len = LenW'($urandom_range(9, PatternMax));
            default: raw_len = LenW'($urandom_range(1, 8));
         endcase
         load_pattern(pat[WordW-1:0], pat[2*WordW-1:WordW], mask, raw_len);
         n = effective_length(raw_len);
         repeat ($urandom_range(3, 8)) begin
            // Near the end of the run both sides stay busy.
            if (live_bytes - start_count > RandomItemTarget - QuietTail) begin
               sender_gaps   = 1'b0;
               receiver_gaps = 1'b0;
            end
            img.delete();
            kind = $urandom_range(0, 9);
            repeat ($urandom_range(0, (kind == 9) ? 20 : 10)) begin
               img.insert(img.size(), byte_type'($urandom()));
            end
            if (kind < 9) begin
               for (int k = 0; k < n; k++) begin
                  img.insert(img.size(), mask[k] ? byte_type'($urandom()) : pat[8*k +: 8]);
               end
               if (kind == 7) begin
                  at = img.size() - n + $urandom_range(0, n - 1);
                  img[at] = img[at] ^ byte_type'($urandom_range(1, 255));
               end else if (kind == 8) begin
                  img.pop_back();
               end
               repeat ($urandom_range(0, 6)) begin
                  img.insert(img.size(), byte_type'($urandom()));
               end
            end
            if (img.size() == 0) begin
               img.insert(img.size(), byte_type'($urandom()));
            end
            foreach (img[i]) begin
               send_byte(img[i], i == img.size() - 1);
            end
         end
      end
   endtask

   // Result side: random stall bursts, or one long hold-off when a test asks for it.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted result is compared field by field with the oldest prediction.
   initial begin
      scan_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result with none expected: found=%0b offset=%0d",
                                         rsp_found, rsp_match_offset));
            end else begin
               want = expected_results.pop_front();
               if (rsp_found !== want.found) begin
                  report_mismatch($sformatf("found: expected %0b, actual %0b",
                                            want.found, rsp_found));
               end
               if (rsp_match_offset !== want.offset) begin
                  report_mismatch($sformatf("match_offset: expected %0d, actual %0d",
                                            want.offset, rsp_match_offset));
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("wildcard_byte_pattern_search_top verification failed");
      $finish;
   end

   initial begin
      clear_scan_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_length_clamping();
      test_final_byte_match();
      test_config_mid_image();
      test_receiver_hold_off();
      test_random_images();
      settle_block();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("wildcard_byte_pattern_search_top verification clean");
      end else begin
         $display("wildcard_byte_pattern_search_top verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/wbps_pkg.sv
rtl/wildcard_byte_pattern_search_top.sv
tb/wildcard_byte_pattern_search_top_tb.sv
